// ===== hw/rtl/piecewise_linear_interp_table_top_macros.svh =====
// Assertion macros for the interpolation table block.
// Used by piecewise_linear_interp_table_top; expects clk_i and rst_ni in scope.
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plit assertion failed");

// Next-cycle implication, checked outside reset.
`define PLIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plit assertion failed");

`endif

// ===== hw/rtl/plit_pkg.sv =====
// Package for the piecewise linear interpolation table.
// Widths, table entry type, opcodes and sequencer states; no dependencies.
package plit_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CFG_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int DIST_W  = 16;
  localparam int SPEED_W = 14;
  localparam int ANGLE_W = 13;

  // Weighted sums stay below 2^30 in magnitude; quotients fit in QUO_W bits.
  localparam int ACC_W = 31;
  localparam int MAG_W = 30;
  localparam int QUO_W = 14;
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = DIST_W + 1;
  localparam int STEP_W  = 4;

  localparam logic OPC_WRITE  = 1'b0;
  localparam logic OPC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0]         distance;
    logic [SPEED_W-1:0]        speed;
    logic signed [ANGLE_W-1:0] angle;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/piecewise_linear_interp_table_top.sv =====
// Piecewise linear interpolation table: breakpoint memory, scan, interpolation.
// Depends on plit_pkg and piecewise_linear_interp_table_top_macros.svh.
//
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. opcode 0 stores one breakpoint into the table in that same edge and
//   leaves busy low. opcode 1 looks up query_distance and raises busy unless
//   fewer than two entries are in use. Config channel: cfg_data_i loads
//   entries_in_use when cfg_valid_i is high; cfg_ready_o is always high. Load it only while busy is low.
//   Result: one word per lookup, on the result ports for a single cycle with
//   result_valid_o high. The receiver cannot stall; it must take it then.
//   Lookup: the breakpoint memory is read once per cycle while the pairs are
//   scanned. A hit then runs the shared multiplier, a setup step that loads
//   the divider and the bit-serial divider before the strobe; a miss or a
//   zero-width pair ends right after the scan, and fewer than two entries
//   give a miss strobe in the cycle after accept.
//   Reset clears the sequencer and entries_in_use; the table contents are
//   undefined until written.
`include "piecewise_linear_interp_table_top_macros.svh"

module piecewise_linear_interp_table_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode_i,
  input  logic [plit_pkg::SLOT_W-1:0]          entry_index_i,
  input  logic [plit_pkg::DIST_W-1:0]          entry_distance_i,
  input  logic [plit_pkg::SPEED_W-1:0]         entry_speed_i,
  input  logic signed [plit_pkg::ANGLE_W-1:0]  entry_angle_i,
  input  logic [plit_pkg::DIST_W-1:0]          query_distance_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [plit_pkg::CFG_W-1:0]           cfg_data_i,
  output logic                                 result_valid_o,
  output logic                                 found_o,
  output logic [plit_pkg::SPEED_W-1:0]         speed_out_o,
  output logic signed [plit_pkg::ANGLE_W-1:0]  angle_out_o,
  output logic [plit_pkg::DIST_W-1:0]          lower_distance_o,
  output logic [plit_pkg::DIST_W-1:0]          upper_distance_o
);

  // One restoring divide step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [plit_pkg::DIST_W+plit_pkg::QUO_W-1:0] div_step(
    input logic [plit_pkg::DIST_W-1:0] rem,
    input logic [plit_pkg::QUO_W-1:0]  dq,
    input logic [plit_pkg::DIST_W-1:0] den
  );
    logic [plit_pkg::DIST_W:0]   trial;
    logic                        ge;
    logic [plit_pkg::DIST_W-1:0] rem_n;
    trial = {rem, dq[plit_pkg::QUO_W-1]};
    ge    = (trial >= {1'b0, den});
    rem_n = ge ? plit_pkg::DIST_W'(trial - {1'b0, den}) : trial[plit_pkg::DIST_W-1:0];
    return {rem_n, dq[plit_pkg::QUO_W-2:0], ge};
  endfunction

  // Breakpoint memory
  plit_pkg::entry_t                    mem_q [plit_pkg::TABLE_DEPTH];
  plit_pkg::entry_t                    rdata_q;
  logic [plit_pkg::IDX_W-1:0]          rd_addr;
  logic                                mem_we;
  plit_pkg::entry_t                    wdata;

  // Sequencer state
  plit_pkg::state_e                    state_q, state_d;
  logic [plit_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [plit_pkg::CNT_W-1:0]          n_q, n_d;
  logic                                have_q, have_d;
  logic [plit_pkg::STEP_W-1:0]         step_q, step_d;
  logic [plit_pkg::CFG_W-1:0]          entries_q, entries_d;
  logic                                res_valid_q, res_valid_d;

  // Datapath
  logic [plit_pkg::DIST_W-1:0]         query_q, query_d;
  plit_pkg::entry_t                    prev_q, prev_d;
  plit_pkg::entry_t                    lo_q, lo_d;
  plit_pkg::entry_t                    hi_q, hi_d;
  logic [plit_pkg::DIST_W-1:0]         den_q, den_d;
  logic [plit_pkg::DIST_W-1:0]         num_q, num_d;
  logic signed [plit_pkg::ACC_W-1:0]   prod_q, prod_d;
  logic signed [plit_pkg::ACC_W-1:0]   acc_s_q, acc_s_d;
  logic signed [plit_pkg::ACC_W-1:0]   acc_a_q, acc_a_d;
  logic [plit_pkg::DIST_W-1:0]         rem_s_q, rem_s_d, rem_a_q, rem_a_d;
  logic [plit_pkg::QUO_W-1:0]          dq_s_q, dq_s_d, dq_a_q, dq_a_d;
  logic                                neg_q, neg_d;

  // Result word
  logic                                found_q, found_d;
  logic [plit_pkg::SPEED_W-1:0]        speed_q, speed_d;
  logic signed [plit_pkg::ANGLE_W-1:0] angle_q, angle_d;
  logic [plit_pkg::DIST_W-1:0]         lo_dist_q, lo_dist_d;
  logic [plit_pkg::DIST_W-1:0]         hi_dist_q, hi_dist_d;

  // Combinational helpers
  logic                                cmd_acc;
  logic [plit_pkg::CNT_W-1:0]          n_sat;
  logic signed [plit_pkg::MUL_A_W-1:0] mul_a;
  logic signed [plit_pkg::MUL_B_W-1:0] mul_b;
  logic signed [plit_pkg::MUL_A_W+plit_pkg::MUL_B_W-1:0] mul_p;
  logic [plit_pkg::ACC_W-1:0]          abs_a;
  logic [plit_pkg::MAG_W-1:0]          mag_s, mag_a;
  logic [plit_pkg::DIST_W+plit_pkg::QUO_W-1:0] step_s, step_a;
  logic [plit_pkg::QUO_W:0]            neg_quo;

  assign busy        = (state_q != plit_pkg::ST_IDLE);
  assign cmd_acc     = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign n_sat = (32'(entries_q) > plit_pkg::TABLE_DEPTH) ?
                 plit_pkg::CNT_W'(plit_pkg::TABLE_DEPTH) : plit_pkg::CNT_W'(entries_q);

  assign mem_we = cmd_acc && (opcode_i == plit_pkg::OPC_WRITE) &&
                  (32'(entry_index_i) < plit_pkg::TABLE_DEPTH);
  assign wdata  = '{distance: entry_distance_i, speed: entry_speed_i,
                    angle: entry_angle_i};
  assign rd_addr = (state_q == plit_pkg::ST_IDLE) ? '0 : plit_pkg::IDX_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[plit_pkg::IDX_W'(entry_index_i)] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Shared multiplier: speed lo*(den-num), speed hi*num, angle lo*(den-num), angle hi*num
  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        mul_a = signed'({2'b00, lo_q.speed});
        mul_b = signed'({1'b0, plit_pkg::DIST_W'(den_q - num_q)});
      end
      2'd1: begin
        mul_a = signed'({2'b00, hi_q.speed});
        mul_b = signed'({1'b0, num_q});
      end
      2'd2: begin
        mul_a = plit_pkg::MUL_A_W'(lo_q.angle);
        mul_b = signed'({1'b0, plit_pkg::DIST_W'(den_q - num_q)});
      end
      default: begin
        mul_a = plit_pkg::MUL_A_W'(hi_q.angle);
        mul_b = signed'({1'b0, num_q});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign abs_a  = acc_a_q[plit_pkg::ACC_W-1] ? plit_pkg::ACC_W'(-acc_a_q) : acc_a_q;
  assign mag_s  = acc_s_q[plit_pkg::MAG_W-1:0];
  assign mag_a  = abs_a[plit_pkg::MAG_W-1:0];
  assign step_s = div_step(rem_s_q, dq_s_q, den_q);
  assign step_a = div_step(rem_a_q, dq_a_q, den_q);
  assign neg_quo = (plit_pkg::QUO_W+1)'(-{1'b0, step_a[plit_pkg::QUO_W-1:0]});

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    have_d      = have_q;
    step_d      = step_q;
    entries_d   = entries_q;
    res_valid_d = 1'b0;
    query_d     = query_q;
    prev_d      = prev_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    den_d       = den_q;
    num_d       = num_q;
    prod_d      = prod_q;
    acc_s_d     = acc_s_q;
    acc_a_d     = acc_a_q;
    rem_s_d     = rem_s_q;
    rem_a_d     = rem_a_q;
    dq_s_d      = dq_s_q;
    dq_a_d      = dq_a_q;
    neg_d       = neg_q;
    found_d     = found_q;
    speed_d     = speed_q;
    angle_d     = angle_q;
    lo_dist_d   = lo_dist_q;
    hi_dist_d   = hi_dist_q;

    if (cfg_valid_i) begin
      entries_d = cfg_data_i;
    end

    unique case (state_q)
      plit_pkg::ST_IDLE: begin
        if (cmd_acc && (opcode_i == plit_pkg::OPC_LOOKUP)) begin
          query_d = query_distance_i;
          n_d     = n_sat;
          if (n_sat < plit_pkg::CNT_W'(2)) begin
            res_valid_d = 1'b1;
            found_d     = 1'b0;
            speed_d     = '0;
            angle_d     = '0;
            lo_dist_d   = '0;
            hi_dist_d   = '0;
          end else begin
            state_d = plit_pkg::ST_SCAN;
            cnt_d   = plit_pkg::CNT_W'(1);
            have_d  = 1'b0;
          end
        end
      end

      // rdata_q holds entry cnt_q-1, prev_q holds entry cnt_q-2
      plit_pkg::ST_SCAN: begin
        if (!have_q) begin
          prev_d = rdata_q;
          have_d = 1'b1;
          cnt_d  = cnt_q + plit_pkg::CNT_W'(1);
        end else if (query_q >= prev_q.distance && query_q <= rdata_q.distance) begin
          lo_d  = prev_q;
          hi_d  = rdata_q;
          den_d = rdata_q.distance - prev_q.distance;
          num_d = query_q - prev_q.distance;
          if (rdata_q.distance == prev_q.distance) begin
            state_d     = plit_pkg::ST_IDLE;
            res_valid_d = 1'b1;
            found_d     = 1'b1;
            speed_d     = prev_q.speed;
            angle_d     = prev_q.angle;
            lo_dist_d   = prev_q.distance;
            hi_dist_d   = rdata_q.distance;
          end else begin
            state_d = plit_pkg::ST_MUL;
            step_d  = '0;
            acc_s_d = '0;
            acc_a_d = '0;
          end
        end else if (cnt_q == n_q) begin
          state_d     = plit_pkg::ST_IDLE;
          res_valid_d = 1'b1;
          found_d     = 1'b0;
          speed_d     = '0;
          angle_d     = '0;
          lo_dist_d   = '0;
          hi_dist_d   = '0;
        end else begin
          prev_d = rdata_q;
          cnt_d  = cnt_q + plit_pkg::CNT_W'(1);
        end
      end

      // steps 0-3 multiply, 1-4 accumulate the previous product, 5 loads the divider
      plit_pkg::ST_MUL: begin
        prod_d = plit_pkg::ACC_W'(mul_p);
        if (step_q == plit_pkg::STEP_W'(1) || step_q == plit_pkg::STEP_W'(2)) begin
          acc_s_d = acc_s_q + prod_q;
        end else if (step_q == plit_pkg::STEP_W'(3) || step_q == plit_pkg::STEP_W'(4)) begin
          acc_a_d = acc_a_q + prod_q;
        end
        step_d = step_q + plit_pkg::STEP_W'(1);
        if (step_q == plit_pkg::STEP_W'(5)) begin
          // quotient < 2^QUO_W, so the top bits are already below den
          rem_s_d = mag_s[plit_pkg::MAG_W-1:plit_pkg::QUO_W];
          dq_s_d  = mag_s[plit_pkg::QUO_W-1:0];
          rem_a_d = mag_a[plit_pkg::MAG_W-1:plit_pkg::QUO_W];
          dq_a_d  = mag_a[plit_pkg::QUO_W-1:0];
          neg_d   = acc_a_q[plit_pkg::ACC_W-1];
          step_d  = '0;
          state_d = plit_pkg::ST_DIV;
        end
      end

      plit_pkg::ST_DIV: begin
        rem_s_d = step_s[plit_pkg::DIST_W+plit_pkg::QUO_W-1:plit_pkg::QUO_W];
        dq_s_d  = step_s[plit_pkg::QUO_W-1:0];
        rem_a_d = step_a[plit_pkg::DIST_W+plit_pkg::QUO_W-1:plit_pkg::QUO_W];
        dq_a_d  = step_a[plit_pkg::QUO_W-1:0];
        step_d  = step_q + plit_pkg::STEP_W'(1);
        if (step_q == plit_pkg::STEP_W'(plit_pkg::QUO_W - 1)) begin
          state_d     = plit_pkg::ST_IDLE;
          res_valid_d = 1'b1;
          found_d     = 1'b1;
          speed_d     = step_s[plit_pkg::SPEED_W-1:0];
          angle_d     = neg_q ? signed'(neg_quo[plit_pkg::ANGLE_W-1:0]) :
                                signed'(step_a[plit_pkg::ANGLE_W-1:0]);
          lo_dist_d   = lo_q.distance;
          hi_dist_d   = hi_q.distance;
        end
      end

      default: begin
        state_d = plit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plit_pkg::ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      have_q      <= 1'b0;
      step_q      <= '0;
      entries_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      have_q      <= have_d;
      step_q      <= step_d;
      entries_q   <= entries_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q   <= query_d;
    prev_q    <= prev_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    den_q     <= den_d;
    num_q     <= num_d;
    prod_q    <= prod_d;
    acc_s_q   <= acc_s_d;
    acc_a_q   <= acc_a_d;
    rem_s_q   <= rem_s_d;
    rem_a_q   <= rem_a_d;
    dq_s_q    <= dq_s_d;
    dq_a_q    <= dq_a_d;
    neg_q     <= neg_d;
    found_q   <= found_d;
    speed_q   <= speed_d;
    angle_q   <= angle_d;
    lo_dist_q <= lo_dist_d;
    hi_dist_q <= hi_dist_d;
  end

  assign result_valid_o   = res_valid_q;
  assign found_o          = found_q;
  assign speed_out_o      = speed_q;
  assign angle_out_o      = angle_q;
  assign lower_distance_o = lo_dist_q;
  assign upper_distance_o = hi_dist_q;

  // every result word leaves the sequencer back in idle
  `PLIT_ASSERT_NOW(a_strobe_idle, result_valid_o, !busy)
  `PLIT_ASSERT_NOW(a_miss_zero, result_valid_o && !found_o,
    speed_out_o == '0 && angle_out_o == '0 && lower_distance_o == '0 &&
    upper_distance_o == '0)
  `PLIT_ASSERT_NOW(a_hit_ordered, result_valid_o && found_o,
    lower_distance_o <= upper_distance_o)
  `PLIT_ASSERT_NOW(a_scan_bounds, state_q == plit_pkg::ST_SCAN,
    cnt_q <= n_q && n_q >= plit_pkg::CNT_W'(2))
  `PLIT_ASSERT_NEXT(a_lookup_busy,
    start && !busy && opcode_i == plit_pkg::OPC_LOOKUP && n_sat >= plit_pkg::CNT_W'(2),
    busy)

endmodule
